// ===== sv/q4_dequant_dot_accumulate_unit_defines.svh =====
// Assertion macros for the q4 dequant dot accumulate unit.
// Included by the top-level RTL file, which carries the concurrent checks; needs nothing else.
`ifndef Q4_DEQUANT_DOT_ACCUMULATE_UNIT_DEFINES_SVH
`define Q4_DEQUANT_DOT_ACCUMULATE_UNIT_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, sampled on i_clk, off during reset.
`define Q4DQ_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("q4dq check failed");
// Next-cycle implication, sampled on i_clk, off during reset.
`define Q4DQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("q4dq check failed");
`else
`define Q4DQ_ASSERT_SAME(label, ante, cons)
`define Q4DQ_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== sv/q4dq_pkg.sv =====
// Shared types, widths and saturation helper for the q4 dequant dot accumulate unit.
// No dependencies; imported by every module of the block.
`default_nettype none

package q4dq_pkg;

    localparam int LANES     = 4;
    localparam int ACC_BITS  = 48;
    localparam int IN_LANES  = 4;
    localparam int OUT_BITS  = 48;
    localparam int USED_LANES = (LANES < IN_LANES) ? LANES : IN_LANES;

    localparam int W_BITS  = 4;
    localparam int ACT_W   = 16;
    localparam int SCALE_W = 16;
    localparam int ZERO_W  = 8;
    localparam int DIFF_W  = W_BITS + 3 + 2;        // weight*8 - zero, signed
    localparam int DS_W    = DIFF_W + SCALE_W;      // diff * scale
    localparam int PROD_W  = DS_W + ACT_W;          // diff * scale * act
    localparam int LSUM_W  = PROD_W + $clog2(IN_LANES);
    localparam int WIDE_W  = ((ACC_BITS > OUT_BITS) ? ACC_BITS : OUT_BITS) + 2;

    typedef logic        [W_BITS-1:0]   t_weight;
    typedef logic signed [ACT_W-1:0]    t_act;
    typedef logic signed [SCALE_W-1:0]  t_scale;
    typedef logic signed [ZERO_W-1:0]   t_zero;
    typedef logic signed [DIFF_W-1:0]   t_diff;
    typedef logic signed [DS_W-1:0]     t_ds;
    typedef logic signed [PROD_W-1:0]   t_prod;
    typedef logic signed [LSUM_W-1:0]   t_lsum;
    typedef logic signed [ACC_BITS-1:0] t_acc;
    typedef logic signed [OUT_BITS-1:0] t_out;
    typedef logic signed [WIDE_W-1:0]   t_wide;

    typedef struct packed {
        logic first;
        logic last;
        t_out start;
    } t_ctrl;

    typedef struct packed {
        t_wide value;
        logic  clip;
    } t_sat;

    localparam t_wide ACC_MAX = {{(WIDE_W-ACC_BITS+1){1'b0}}, {(ACC_BITS-1){1'b1}}};
    localparam t_wide OUT_MAX = {{(WIDE_W-OUT_BITS+1){1'b0}}, {(OUT_BITS-1){1'b1}}};

    // Clamp v to [-hi-1, hi] and report whether it clipped.
    function automatic t_sat sat_clamp(input t_wide v, input t_wide hi);
        t_sat  r;
        t_wide lo;
        lo = ~hi;
        if (v > hi) begin
            r.value = hi;
            r.clip  = 1'b1;
        end else if (v < lo) begin
            r.value = lo;
            r.clip  = 1'b1;
        end else begin
            r.value = v;
            r.clip  = 1'b0;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== sv/q4dq_lane.sv =====
// One dequantize-and-multiply lane: (weight*8 - zero) * scale, then * activation.
// Two registered multiply stages; depends on q4dq_pkg.
`default_nettype none

module q4dq_lane
    import q4dq_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_en,
    input  wire t_weight i_weight,
    input  wire t_act    i_act,
    input  wire t_scale  i_scale,
    input  wire t_zero   i_zero,
    output t_prod        o_prod
);

    t_diff w_diff;
    t_ds   r_ds;
    t_act  r_act;
    t_prod r_prod;

    // Weight in Q.3 minus zero point in Q.3.
    assign w_diff = $signed({2'b00, i_weight, 3'b000}) - t_diff'(i_zero);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ds   <= t_ds'(w_diff) * t_ds'(i_scale);
            r_act  <= i_act;
            r_prod <= t_prod'(r_ds) * t_prod'(r_act);
        end
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

// ===== sv/q4dq_merge.sv =====
// Lane merge: adds the lane products into one registered lane sum.
// Depends on q4dq_pkg.
`default_nettype none

module q4dq_merge
    import q4dq_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_en,
    input  wire t_prod i_prod [USED_LANES],
    output t_lsum      o_sum
);

    t_lsum w_sum;
    t_lsum r_sum;

    always_comb begin
        w_sum = '0;
        for (int i = 0; i < USED_LANES; i++) begin
            w_sum = w_sum + t_lsum'(i_prod[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum <= w_sum;
        end
    end

    assign o_sum = r_sum;

endmodule

`default_nettype wire

// ===== sv/q4_dequant_dot_accumulate_unit.sv =====
// Q4 group-dequantize dot accumulate unit, top level (uses q4dq_pkg, q4dq_lane, q4dq_merge).
// Throughput: one item per cycle, also across row boundaries, while the pipe is not stalled.
// Path: a row's result passes the registered lane multiply, lane multiply and merge add,
//   then is accumulated into the output register.
// The only stall is a last-of-row item reaching the accumulator while the output register is full and not taken.
// Reset (synchronous, active low) clears accumulator, clip flag and all valid bits.
`default_nettype none

`include "q4_dequant_dot_accumulate_unit_defines.svh"

module q4_dequant_dot_accumulate_unit
    import q4dq_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // input channel
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic [15:0]           i_weights_packed,
    input  wire t_act                  i_act_0,
    input  wire t_act                  i_act_1,
    input  wire t_act                  i_act_2,
    input  wire t_act                  i_act_3,
    input  wire t_scale                i_group_scale,
    input  wire t_zero                 i_zero_point,
    input  wire t_out                  i_start_value,
    input  wire logic                  i_first_of_row,
    input  wire logic                  i_last_of_row,
    // result channel
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output t_out                       o_row_sum,
    output logic                       o_saturated
);

    // ------------------------------------------------------------------
    // Pipeline control. Stage 1 and 2 sit in the lanes, stage 3 is the
    // merged lane sum, and the accumulator consumes stage 3.
    // ------------------------------------------------------------------
    logic  w_in_xfer;
    logic  w_en;
    logic  w_stall;
    logic  w_acc_fire;
    logic  w_emit;

    logic  r_v1, r_v2, r_v3;
    t_ctrl r_c1, r_c2, r_c3;

    t_act  w_act  [IN_LANES];
    t_prod w_prod [USED_LANES];
    t_lsum w_lsum;

    t_acc  r_acc;
    logic  r_clip;
    t_acc  n_acc;
    logic  n_clip;

    logic  r_out_valid;
    t_out  r_out_sum;
    logic  r_out_sat;
    t_out  n_out_sum;
    logic  n_out_sat;

    t_sat  w_start_sat;
    t_wide w_base;
    logic  w_base_clip;
    t_sat  w_sum_sat;
    t_sat  w_out_sat;

    // Hold the whole pipe only when a row result must enter a full output register.
    assign w_stall    = r_v3 && r_c3.last && r_out_valid && !i_ready;
    assign w_en       = !w_stall;
    assign o_ready    = w_en;
    assign w_in_xfer  = i_valid && w_en;
    assign w_acc_fire = r_v3 && w_en;
    assign w_emit     = w_acc_fire && r_c3.last;

    // Valid bits travel with the items.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= w_in_xfer;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // Row marks and start value follow the lane data stage by stage.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c1 <= '{first: i_first_of_row, last: i_last_of_row, start: i_start_value};
            r_c2 <= r_c1;
            r_c3 <= r_c2;
        end
    end

    // ------------------------------------------------------------------
    // Lanes: dequantize and multiply each carried weight.
    // ------------------------------------------------------------------
    assign w_act[0] = i_act_0;
    assign w_act[1] = i_act_1;
    assign w_act[2] = i_act_2;
    assign w_act[3] = i_act_3;

    for (genvar g = 0; g < USED_LANES; g++) begin : g_lane
        q4dq_lane u_lane (
            .i_clk    (i_clk),
            .i_en     (w_en),
            .i_weight (i_weights_packed[g*W_BITS +: W_BITS]),
            .i_act    (w_act[g]),
            .i_scale  (i_group_scale),
            .i_zero   (i_zero_point),
            .o_prod   (w_prod[g])
        );
    end

    q4dq_merge u_merge (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_prod (w_prod),
        .o_sum  (w_lsum)
    );

    // ------------------------------------------------------------------
    // Accumulator: load on first of row, saturating add, emit on last.
    // ------------------------------------------------------------------
    always_comb begin
        w_start_sat = sat_clamp(t_wide'(r_c3.start), ACC_MAX);
        if (r_c3.first) begin
            w_base      = w_start_sat.value;
            w_base_clip = w_start_sat.clip;
        end else begin
            w_base      = t_wide'(r_acc);
            w_base_clip = r_clip;
        end
        w_sum_sat = sat_clamp(w_base + t_wide'(w_lsum), ACC_MAX);
        n_acc     = w_sum_sat.value[ACC_BITS-1:0];
        n_clip    = w_base_clip || w_sum_sat.clip;
        // Narrow to the output width; clipping here marks only this result.
        w_out_sat = sat_clamp(t_wide'(n_acc), OUT_MAX);
        n_out_sum = w_out_sat.value[OUT_BITS-1:0];
        n_out_sat = n_clip || w_out_sat.clip;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_clip <= 1'b0;
        end else if (w_acc_fire) begin
            r_acc  <= n_acc;
            r_clip <= n_clip;
        end
    end

    // Output register: load on emit, drop on transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_sum <= n_out_sum;
            r_out_sat <= n_out_sat;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_row_sum   = r_out_sum;
    assign o_saturated = r_out_sat;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `Q4DQ_ASSERT_NEXT(a_emit_shows_result, w_emit, o_valid)
    `Q4DQ_ASSERT_NEXT(a_xfer_enters_pipe, i_valid && o_ready, r_v1)
    `Q4DQ_ASSERT_SAME(a_stall_needs_row_end, !(r_v3 && r_c3.last), o_ready)

endmodule

`default_nettype wire
